>>> sv/ebj_pkg.sv
// Shared constants, register indexes and control types for the backoff jitter unit.
package ebj_pkg;

    localparam int DELAY_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int GROWTH_W   = 13;
    localparam int JIT_W      = 17;
    localparam int JIT_FRAC   = 16;
    localparam int OUT_W      = 32;
    localparam int S_TDATA_W  = 24;
    localparam int CHUNK_W    = 16;
    localparam int DIGIT_W    = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_INITIAL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GROWTH  = 2'd2;

    localparam logic [CFG_W-1:0]    INITIAL_RST = 32'd1000;
    localparam logic [CFG_W-1:0]    MAX_RST     = 32'd60000;
    localparam logic [GROWTH_W-1:0] GROWTH_RST  = 13'd512;
    localparam logic [GROWTH_W-1:0] GROWTH_ONE  = 13'd256;
    localparam logic [OUT_W-1:0]    OUT_MAX     = 32'hFFFF_FFFF;

    localparam logic ACTION_NEXT  = 1'b0;
    localparam logic ACTION_RESET = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic item_load;
        logic first_load;
        logic mul_start;
        logic mul_sel_jit;
        logic grow_commit;
        logic div_start;
        logic out_load;
    } ebj_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_busy;
        logic div_busy;
    } ebj_sts_t;

endpackage

>>> sv/exponential_backoff_jitter_unit.sv
// Top level of the capped exponential backoff unit with jitter.
// An accepted 'next' transaction loads the initial delay for the first delay of a sequence, else
// grows the kept one, then runs the jitter multiply and divisions. NDG = ceil((DELAY_WIDTH+4)/4)
// divide-by-ten digits outlast the NCH = ceil((DELAY_WIDTH+FRACTION_BITS)/16) jitter multiply steps.
// Throughput: one request in work at a time, the next taken in the cycle after the result loads,
// later while a result waits. A 'reset' transaction restarts the sequence; rst_n restores defaults.
module exponential_backoff_jitter_unit #(
    parameter int DELAY_WIDTH   = ebj_pkg::DELAY_WIDTH_DEF,
    parameter int FRACTION_BITS = ebj_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port: index 0 initial_delay, 1 max_delay, 2 growth_factor.
    input  logic                           cfg_we,
    input  logic [ebj_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ebj_pkg::CFG_W-1:0]      cfg_wdata,
    // Request stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ebj_pkg::S_TDATA_W-1:0]  s_tdata,   // [16:0] jitter_factor, rest zero
    input  logic [0:0]                     s_tuser,   // [0] action
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ebj_pkg::OUT_W-1:0]      m_tdata    // [31:0] delay_ms
);
    import ebj_pkg::*;

    ebj_cmd_t cmd;
    ebj_sts_t sts;

    // The controller decides between loading the initial delay and growing the kept one,
    // then runs the jitter multiply and both bound divisions side by side. A finished result
    // sits in the output register, and a new request is taken while it waits for the sink.
    ebj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath keeps the scaled delay in fixed point with FRACTION_BITS fraction bits,
    // capped at max_delay limited to DELAY_WIDTH bits, and shares one chunk-serial
    // multiplier between the growth step and the jitter product.
    ebj_dp #(
        .DELAY_WIDTH   (DELAY_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .jitter_factor (s_tdata[JIT_W-1:0]),
        .cmd           (cmd),
        .sts           (sts),
        .delay_ms      (m_tdata)
    );

endmodule

>>> sv/ebj_mul.sv
// Chunk-serial multiplier: 16 bits of the multiplicand per cycle, most significant first.
module ebj_mul #(
    parameter int AW = 48,
    parameter int BW = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             busy,
    output logic [AW+BW-1:0] p
);
    import ebj_pkg::*;

    localparam int NCH   = (AW + CHUNK_W - 1) / CHUNK_W;
    localparam int PAW   = NCH * CHUNK_W;
    localparam int ACC_W = PAW + BW;
    localparam int CNT_W = $clog2(NCH + 1);

    logic [PAW-1:0]         a_reg;
    logic [BW-1:0]          b_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       acc_next;
    logic [CHUNK_W+BW-1:0]  part;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;

    assign part     = a_reg[PAW-1 -: CHUNK_W] * b_reg;
    assign acc_next = (acc_reg << CHUNK_W) + ACC_W'(part);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NCH);
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != CNT_W'(1));
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= PAW'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= a_reg << CHUNK_W;
            acc_reg <= acc_next;
        end
    end

    assign busy = busy_reg;
    assign p    = acc_reg[AW+BW-1:0];

endmodule

>>> sv/ebj_div10.sv
// Digit-serial divide by ten, one 4-bit digit of the dividend per cycle.
module ebj_div10 #(
    parameter int XW = 36
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [XW-1:0] x,
    output logic          busy,
    output logic [XW-1:0] q
);
    import ebj_pkg::*;

    localparam int NDG   = (XW + DIGIT_W - 1) / DIGIT_W;
    localparam int PXW   = NDG * DIGIT_W;
    localparam int CNT_W = $clog2(NDG + 1);

    logic [PXW-1:0]     x_reg;
    logic [PXW-1:0]     q_reg;
    logic [DIGIT_W-1:0] r_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [7:0]         v;
    logic [DIGIT_W-1:0] qd;
    logic [7:0]         r_full;

    assign v = {r_reg, x_reg[PXW-1 -: DIGIT_W]};

    // The partial remainder stays below 160, so the digit is a count of thresholds.
    always_comb
    begin
        qd = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (v >= 8'(10 * k))
            begin
                qd = DIGIT_W'(k);
            end
        end
    end

    assign r_full = v - {1'b0, qd, 3'b000} - {3'b000, qd, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NDG);
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != CNT_W'(1));
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= PXW'(x);
            q_reg <= '0;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= x_reg << DIGIT_W;
            q_reg <= {q_reg[PXW-DIGIT_W-1:0], qd};
            r_reg <= r_full[DIGIT_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign q    = q_reg[XW-1:0];

endmodule

>>> sv/ebj_dp.sv
// Datapath: configuration registers, kept delay, shared multiplier, bound dividers and output.
module ebj_dp #(
    parameter int DELAY_WIDTH   = ebj_pkg::DELAY_WIDTH_DEF,
    parameter int FRACTION_BITS = ebj_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ebj_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ebj_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic [ebj_pkg::JIT_W-1:0]      jitter_factor,
    input  ebj_pkg::ebj_cmd_t              cmd,
    output ebj_pkg::ebj_sts_t              sts,
    output logic [ebj_pkg::OUT_W-1:0]      delay_ms
);
    import ebj_pkg::*;

    localparam int DW  = DELAY_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int SW  = DW + FB;
    localparam int IW  = (DW > CFG_W) ? DW : CFG_W;
    localparam int PW  = SW + JIT_W;
    localparam int GW  = PW - 8;
    localparam int XW  = DW + 4;
    localparam int CW  = (SW + 2 > OUT_W + 1) ? SW + 2 : OUT_W + 1;
    localparam logic [IW-1:0] CAP_LIM = (IW'(1) << DW) - IW'(1);
    localparam logic [PW:0]   JIT_HALF = (PW + 1)'(1) << (JIT_FRAC - 1);

    logic [CFG_W-1:0]    init_reg;
    logic [CFG_W-1:0]    max_reg;
    logic [GROWTH_W-1:0] growth_reg;
    logic [JIT_W-1:0]    jit_reg;
    logic [SW-1:0]       scaled_reg;
    logic [SW-1:0]       scaled_next;
    logic [OUT_W-1:0]    out_reg;

    logic [IW-1:0]       max_ext;
    logic [IW-1:0]       cap;
    logic [SW-1:0]       cap_scaled;
    logic [IW+FB-1:0]    init_scaled;
    logic [SW-1:0]       first_scaled;
    logic [GROWTH_W-1:0] g_eff;
    logic [DW-1:0]       base;

    logic [SW-1:0]       mul_a;
    logic [JIT_W-1:0]    mul_b;
    logic [PW-1:0]       mul_p;
    logic                mul_busy;
    logic                ovf;
    logic [GW-1:0]       grown;
    logic [SW-1:0]       grown_capped;

    logic [XW-1:0]       x9;
    logic [XW-1:0]       x11;
    logic [XW-1:0]       lo_q;
    logic [XW-1:0]       hi_q;
    logic                lo_busy;
    logic                hi_busy;

    logic [PW:0]         rnd;
    logic [CW-1:0]       val;
    logic [CW-1:0]       lo_b;
    logic [CW-1:0]       hi_b;
    logic [CW-1:0]       clamped;
    logic [OUT_W-1:0]    result;

    // Cap on the base delay, limited to the delay width.
    assign max_ext    = IW'(max_reg);
    assign cap        = (max_ext < CAP_LIM) ? max_ext : CAP_LIM;
    assign cap_scaled = {cap[DW-1:0], {FB{1'b0}}};

    assign init_scaled  = {IW'(init_reg), {FB{1'b0}}};
    assign first_scaled = (init_scaled < (IW + FB)'(cap_scaled)) ? SW'(init_scaled)
                                                                  : cap_scaled;

    assign g_eff = (growth_reg < GROWTH_ONE) ? GROWTH_ONE : growth_reg;
    assign base  = scaled_reg[SW-1:FB];

    assign mul_a = cmd.mul_sel_jit ? SW'(base) : scaled_reg;
    assign mul_b = cmd.mul_sel_jit ? jit_reg : JIT_W'(g_eff);

    ebj_mul #(
        .AW (SW),
        .BW (JIT_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .p     (mul_p)
    );

    // A growth product that does not fit 64 bits saturates to the cap.
    if (PW > 64)
    begin : g_ovf
        assign ovf = |mul_p[PW-1:64];
    end
    else
    begin : g_no_ovf
        assign ovf = 1'b0;
    end

    assign grown        = mul_p[PW-1:8];
    assign grown_capped = (ovf || !(grown < GW'(cap_scaled))) ? cap_scaled : SW'(grown);

    always_comb
    begin
        scaled_next = scaled_reg;
        if (cmd.first_load)
        begin
            scaled_next = first_scaled;
        end
        else if (cmd.grow_commit)
        begin
            scaled_next = grown_capped;
        end
    end

    // Bounds: floor(9*base/10) and ceil(11*base/10).
    assign x9  = (XW'(base) << 3) + XW'(base);
    assign x11 = (XW'(base) << 3) + (XW'(base) << 1) + XW'(base) + XW'(9);

    ebj_div10 #(
        .XW (XW)
    ) u_div_lo (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .x     (x9),
        .busy  (lo_busy),
        .q     (lo_q)
    );

    ebj_div10 #(
        .XW (XW)
    ) u_div_hi (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .x     (x11),
        .busy  (hi_busy),
        .q     (hi_q)
    );

    // Rounded jitter product, clamped, floored at one and saturated.
    assign rnd  = (PW + 1)'(mul_p) + JIT_HALF;
    assign val  = CW'(rnd[PW:JIT_FRAC]);
    assign lo_b = CW'(lo_q);
    assign hi_b = CW'(hi_q);

    always_comb
    begin
        clamped = val;
        if (val < lo_b)
        begin
            clamped = lo_b;
        end
        else if (val > hi_b)
        begin
            clamped = hi_b;
        end
        if (clamped == '0)
        begin
            clamped = CW'(1);
        end
        if (clamped > CW'(OUT_MAX))
        begin
            result = OUT_MAX;
        end
        else
        begin
            result = clamped[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg   <= INITIAL_RST;
            max_reg    <= MAX_RST;
            growth_reg <= GROWTH_RST;
            scaled_reg <= '0;
        end
        else
        begin
            scaled_reg <= scaled_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_INITIAL: init_reg   <= cfg_wdata;
                    REG_MAX:     max_reg    <= cfg_wdata;
                    REG_GROWTH:  growth_reg <= cfg_wdata[GROWTH_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            jit_reg <= jitter_factor;
        end
        if (cmd.out_load)
        begin
            out_reg <= result;
        end
    end

    assign sts.mul_busy = mul_busy;
    assign sts.div_busy = lo_busy || hi_busy;
    assign delay_ms     = out_reg;

`ifndef SYNTHESIS
    a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_reg != '0)
        else $error("delay output loaded as zero");

    a_grow_capped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grow_commit |=> scaled_reg <= $past(cap_scaled))
        else $error("kept delay exceeds cap after growth");

    a_dividers_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        lo_busy == hi_busy)
        else $error("bound dividers out of step");
`endif

endmodule

>>> sv/ebj_ctrl.sv
// Controller: sequences the growth step, jitter multiply, bound division and output load.
module ebj_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              action,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ebj_pkg::ebj_sts_t sts,
    output ebj_pkg::ebj_cmd_t cmd
);
    import ebj_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GROW = 3'd1;
    localparam logic [2:0] ST_BASE = 3'd2;
    localparam logic [2:0] ST_JIT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       started_reg;
    logic       started_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        started_next = started_reg;
        s_tready     = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (action == ACTION_RESET)
                    begin
                        started_next = 1'b0;
                    end
                    else
                    begin
                        cmd.item_load = 1'b1;
                        if (started_reg)
                        begin
                            cmd.mul_start = 1'b1;
                            state_next    = ST_GROW;
                        end
                        else
                        begin
                            cmd.first_load = 1'b1;
                            state_next     = ST_BASE;
                        end
                    end
                end
            end
            ST_GROW:
            begin
                if (!sts.mul_busy)
                begin
                    cmd.grow_commit = 1'b1;
                    state_next      = ST_BASE;
                end
            end
            ST_BASE:
            begin
                cmd.mul_start   = 1'b1;
                cmd.mul_sel_jit = 1'b1;
                cmd.div_start   = 1'b1;
                state_next      = ST_JIT;
            end
            ST_JIT:
            begin
                if (!sts.mul_busy && !sts.div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    started_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && action == ACTION_RESET) |=> !started_reg)
        else $error("reset request did not restart the sequence");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

    a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!sts.mul_busy && !sts.div_busy))
        else $error("arithmetic unit busy while idle");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the capped exponential backoff unit with jitter.
module tb;
    import ebj_pkg::*;

    localparam int DELAY_BITS    = DELAY_WIDTH_DEF;
    localparam int FRAC_BITS     = FRACTION_BITS_DEF;
    // Wait after draining, ample for a request still in work to finish before a register write.
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PRINT_LIMIT   = 100;

    // Nominal jitter range, about 0.9 to 1.1 in Q1.16.
    localparam logic [JIT_W-1:0] JIT_LOW  = 17'd58982;
    localparam logic [JIT_W-1:0] JIT_ONE  = 17'd65536;
    localparam logic [JIT_W-1:0] JIT_HIGH = 17'd72090;
    localparam logic [JIT_W-1:0] JIT_TOP  = 17'h1FFFF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_INITIAL;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = ACTION_NEXT;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;

    // Shadow copy of the registers and of the sequence state, kept by the predictor.
    logic [CFG_W-1:0]    shadow_initial = INITIAL_RST;
    logic [CFG_W-1:0]    shadow_max     = MAX_RST;
    logic [GROWTH_W-1:0] shadow_growth  = GROWTH_RST;
    bit                  seq_started    = 1'b0;
    logic [63:0]         kept_delay     = '0;

    // Delays that the block still owes us, oldest first.
    logic [OUT_W-1:0] pending_delays[$];

    // When set, neither side inserts idle cycles.
    bit full_rate = 1'b0;

    int mismatches     = 0;
    int requests_sent  = 0;
    int delays_checked = 0;
    int settings_used  = 0;

    exponential_backoff_jitter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    // Advances the predicted backoff sequence by one 'next' request and returns the
    // jittered delay that the block must produce for it.
    function automatic logic [OUT_W-1:0] next_retry_delay(input logic [JIT_W-1:0] jit);
        logic [63:0]         cap_ms;
        logic [63:0]         cap_scaled;
        logic [63:0]         first_scaled;
        logic [GROWTH_W-1:0] growth;
        logic [76:0]         product;
        logic [63:0]         base;
        logic [63:0]         jittered;
        logic [63:0]         lower_bound;
        logic [63:0]         upper_bound;

        cap_ms = 64'(shadow_max);
        if (cap_ms > (64'd1 << DELAY_BITS) - 64'd1)
        begin
            cap_ms = (64'd1 << DELAY_BITS) - 64'd1;
        end
        cap_scaled = cap_ms << FRAC_BITS;

        if (!seq_started)
        begin
            // The first delay of a sequence is the initial delay, also held to the cap.
            first_scaled = 64'(shadow_initial) << FRAC_BITS;
            kept_delay   = (first_scaled < cap_scaled) ? first_scaled : cap_scaled;
        end
        else
        begin
            // A growth factor below one is treated as one, so the delay never shrinks.
            growth  = (shadow_growth < GROWTH_ONE) ? GROWTH_ONE : shadow_growth;
            product = 77'(kept_delay) * 77'(growth);
            if (product[76:64] != '0)
            begin
                kept_delay = cap_scaled;
            end
            else
            begin
                kept_delay = product[63:0] >> 8;
                if (kept_delay > cap_scaled)
                begin
                    kept_delay = cap_scaled;
                end
            end
        end
        seq_started = 1'b1;

        // Jitter is rounded half up, then held within 0.9 and 1.1 of the base.
        base        = kept_delay >> FRAC_BITS;
        jittered    = (base * 64'(jit) + 64'd32768) >> JIT_FRAC;
        lower_bound = (base * 64'd9) / 64'd10;
        upper_bound = (base * 64'd11 + 64'd9) / 64'd10;
        if (jittered < lower_bound)
        begin
            jittered = lower_bound;
        end
        else if (jittered > upper_bound)
        begin
            jittered = upper_bound;
        end
        if (jittered < 64'd1)
        begin
            jittered = 64'd1;
        end
        if (jittered > 64'(OUT_MAX))
        begin
            jittered = 64'(OUT_MAX);
        end
        return jittered[OUT_W-1:0];
    endfunction

    // Picks a delay register value, weighted toward the corners.
    function automatic logic [CFG_W-1:0] pick_delay_value();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return CFG_W'($urandom_range(1, 50));
            2: return CFG_W'($urandom_range(100, 100000));
            3: return CFG_W'($urandom);
            4: return OUT_MAX;
            5: return OUT_MAX - CFG_W'($urandom_range(0, 1000));
            default: return CFG_W'($urandom_range(1, 5000));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_delay(input logic [OUT_W-1:0] seen);
        logic [OUT_W-1:0] owed;

        delays_checked++;
        if (pending_delays.size() == 0)
        begin
            report_mismatch($sformatf("delay_ms %0d arrived with nothing outstanding", seen));
        end
        else
        begin
            owed = pending_delays.pop_front();
            if (seen !== owed)
            begin
                report_mismatch($sformatf("delay_ms is %0d, predicted %0d", seen, owed));
            end
        end
    endtask

    // Writes one register. Called at a rising edge; returns at a rising edge.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_INITIAL: shadow_initial = value;
            REG_MAX:     shadow_max     = value;
            REG_GROWTH:  shadow_growth  = value[GROWTH_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] initial_ms, input logic [CFG_W-1:0] max_ms,
                             input logic [GROWTH_W-1:0] growth);
        write_reg(REG_INITIAL, initial_ms);
        write_reg(REG_MAX, max_ms);
        write_reg(REG_GROWTH, CFG_W'(growth));
        settings_used++;
    endtask

    // Sends one request and, once the block takes the transaction, records what it owes.
    // tvalid is left high so that a following request can go out back to back.
    task automatic send_request(input logic action, input logic [JIT_W-1:0] jit);
        int gap;
        bit taken;

        gap = 0;
        if (!full_rate && $urandom_range(0, 99) < 30)
        begin
            gap = $urandom_range(1, 20);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(jit);
        s_tuser  <= action;

        // Handshake signals are stable between the falling edge and the next rising edge.
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end

        requests_sent++;
        if (action == ACTION_RESET)
        begin
            seq_started = 1'b0;
        end
        else
        begin
            pending_delays.push_back(next_retry_delay(jit));
        end
    endtask

    // Lets all outstanding delays arrive, then gives a trailing reset request time to finish,
    // so that the block is idle before any register write.
    task automatic wait_idle();
        int waited;

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_delays.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // With the reset register values the delay doubles from 1000 ms up to the 60000 ms cap,
    // while the jitter walks through its nominal and out-of-range extremes.
    task automatic test_default_sequence();
        send_request(ACTION_RESET, JIT_ONE);
        send_request(ACTION_NEXT, JIT_ONE);
        send_request(ACTION_NEXT, JIT_LOW);
        send_request(ACTION_NEXT, JIT_HIGH);
        send_request(ACTION_NEXT, '0);
        send_request(ACTION_NEXT, JIT_TOP);
        send_request(ACTION_NEXT, 17'd1);
        send_request(ACTION_NEXT, JIT_ONE);
        wait_idle();
    endtask

    // Register corners: zero base, saturation at 32 bits, growth factors below one and above
    // sixteen, and an initial delay above the cap.
    task automatic test_register_corners();
        configure('0, 32'd100, 13'd4096);
        send_request(ACTION_NEXT, JIT_HIGH);
        send_request(ACTION_NEXT, JIT_TOP);
        wait_idle();

        configure(OUT_MAX, OUT_MAX, 13'd0);
        send_request(ACTION_NEXT, JIT_HIGH);
        send_request(ACTION_NEXT, JIT_TOP);
        send_request(ACTION_RESET, JIT_LOW);
        send_request(ACTION_NEXT, '0);
        wait_idle();

        configure(32'd5000, 32'd3000, 13'h1FFF);
        send_request(ACTION_RESET, JIT_ONE);
        send_request(ACTION_NEXT, JIT_LOW);
        send_request(ACTION_NEXT, JIT_HIGH);
        wait_idle();

        configure(32'd3, OUT_MAX, 13'h1FFF);
        send_request(ACTION_RESET, JIT_ONE);
        send_request(ACTION_NEXT, JIT_ONE);
        send_request(ACTION_NEXT, JIT_LOW);
        send_request(ACTION_NEXT, JIT_HIGH);
        wait_idle();
    endtask

    // Random register settings, each followed by bursts of 'next' requests that start with a
    // reset request, mixed with stray requests carrying arbitrary jitter.
    task automatic test_random_traffic(input int item_goal);
        int                  start_count;
        int                  phase;
        int                  phase_end;
        int                  burst;
        logic [GROWTH_W-1:0] growth;
        logic [JIT_W-1:0]    jit;

        start_count = requests_sent;
        phase = 0;
        while (requests_sent - start_count < item_goal)
        begin
            case ($urandom_range(0, 5))
                0: growth = GROWTH_W'($urandom_range(0, 255));
                1: growth = GROWTH_ONE;
                2: growth = GROWTH_W'($urandom_range(257, 4096));
                3: growth = GROWTH_W'($urandom_range(4097, 8191));
                4: growth = 13'h1FFF;
                default: growth = GROWTH_W'($urandom_range(300, 1024));
            endcase
            configure(pick_delay_value(), pick_delay_value(), growth);

            // One long phase runs with no idle cycles on either side.
            full_rate = (phase == 3);
            phase_end = requests_sent + (full_rate ? 120 : $urandom_range(30, 80));
            while (requests_sent < phase_end)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    send_request(ACTION_RESET, JIT_W'($urandom));
                    burst = $urandom_range(1, 14);
                    repeat (burst)
                    begin
                        case ($urandom_range(0, 19))
                            0: jit = JIT_W'($urandom);
                            1: jit = JIT_W'($urandom);
                            2: jit = ($urandom_range(0, 1) != 0) ? JIT_TOP : '0;
                            default: jit = JIT_W'($urandom_range(JIT_LOW, JIT_HIGH));
                        endcase
                        send_request(ACTION_NEXT, jit);
                    end
                end
                else
                begin
                    send_request(1'($urandom), JIT_W'($urandom));
                end
            end
            wait_idle();
            full_rate = 1'b0;
            phase++;
        end
    endtask

    // Result side: tready is chosen at each rising edge and the handshake is sampled at the
    // falling edge, then checked at the edge where the transaction completes.
    initial
    begin
        bit               took;
        logic [OUT_W-1:0] seen;

        took = 1'b0;
        seen = '0;
        forever
        begin
            @(posedge clk);
            if (took)
            begin
                check_delay(seen);
            end
            m_tready <= full_rate || ($urandom_range(0, 99) >= 30);
            @(negedge clk);
            took = m_tvalid && m_tready;
            seen = m_tdata;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_sequence();
        test_register_corners();
        test_random_traffic(1200);

        if (pending_delays.size() != 0)
        begin
            report_mismatch($sformatf("%0d predicted delays never arrived",
                                      pending_delays.size()));
        end
        $display("Sent %0d requests under %0d register settings plus the reset values;",
                 requests_sent, settings_used);
        $display("checked %0d delays, %0d errors.", delays_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
